// ----- rtl/hwf_pkg.sv -----
// ----------------------------------------------------------------------------
// hwf_pkg - shared definitions for the holonomic waypoint follower
// Waypoint table, register indexes, fixed-point constants and helper types.
// ----------------------------------------------------------------------------
package hwf_pkg;

  localparam int NUM_WAYPOINTS_DEF = 9;
  localparam int TABLE_LEN         = 9;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_TOL_LIN   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TOL_ANG   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LIN_SPEED = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ANG_SPEED = 2'd3;

  localparam logic [15:0] TOL_LIN_RST   = 16'd3277;
  localparam logic [15:0] TOL_ANG_RST   = 16'd5719;
  localparam logic [14:0] LIN_SPEED_RST = 15'd8192;
  localparam logic [14:0] ANG_SPEED_RST = 15'd5407;

  // Q16.16 constants
  localparam logic [16:0] ONE_Q       = 17'd65536;
  localparam logic [31:0] OFFSET_Q    = 32'd65536;
  localparam logic [19:0] TWO_PI_Q    = 20'd411775;
  localparam logic [19:0] FOUR_PI_Q   = 20'd823550;
  localparam logic [19:0] PI_Q        = 20'd205887;
  localparam logic [19:0] HALF_PI_Q   = 20'd102944;

  // reciprocals for exact floor division of values below 2^18
  localparam logic [18:0] RECIP_30 = 19'd279621;  // ceil(2^23 / 30)
  localparam logic [18:0] RECIP_12 = 19'd349526;  // ceil(2^22 / 12)

  typedef struct packed {
    logic [18:0] yaw;
    logic        x_pos;
    logic        x_neg;
    logic        y_pos;
    logic        y_neg;
  } wp_t;

  // per-request side band carried down the cosine pipeline
  typedef struct packed {
    logic       x_pos;
    logic       x_neg;
    logic       y_pos;
    logic       y_neg;
    logic       h_pos;
    logic       h_neg;
    logic [3:0] wp_now;
    logic       finished;
  } side_t;

  function automatic wp_t wp_entry(input logic [7:0] i);
    wp_t w;
    w = '0;
    case (i)
      8'd0: begin w.x_pos = 1'b1; w.y_neg = 1'b1; end
      8'd1: begin w.x_pos = 1'b1; w.y_pos = 1'b1; end
      8'd2: begin w.x_pos = 1'b1; w.y_pos = 1'b1; end
      8'd3: begin w.yaw = 19'sd102944; w.x_pos = 1'b1; w.y_neg = 1'b1; end
      8'd4: begin w.yaw = -19'sd205883; w.x_neg = 1'b1; w.y_neg = 1'b1; end
      8'd5: begin w.x_neg = 1'b1; w.y_pos = 1'b1; end
      8'd6: begin w.x_neg = 1'b1; w.y_pos = 1'b1; end
      8'd7: begin w.x_neg = 1'b1; w.y_neg = 1'b1; end
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [17:0] v);
    logic [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'h7fff;
    end else if (v < -18'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/holonomic_waypoint_follower_core.sv -----
// ----------------------------------------------------------------------------
// holonomic_waypoint_follower_core - four-wheel waypoint follower
// Walks a fixed list of relative waypoints and mixes wheel speed commands.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries requests: s_tuser selects a pose update (0) or a
//   control tick (1). A pose update stores the pose and gives no result; a
//   tick gives one result on the master channel with four saturated wheel
//   commands, the current waypoint index and the finished flag.
//   A request is taken at every clock in which s_tvalid and s_tready are high.
//   Throughput is one request per cycle while s_tready is high. Waypoint state
//   is updated in the input stage, so each request sees the state left by the
//   one before. The wheel magnitude needs the cosine of the heading error, a
//   chain of six multiplies with a register after each; a tick result passes
//   the input, stage and output registers before it shows on m_tvalid.
//   When the receiver stalls, results wait in the output register and the
//   stages behind it keep filling; s_tready drops only once the whole
//   pipeline is full. Reset (rst, synchronous) clears pose, goal and waypoint
//   index, arms a new setpoint, empties the pipeline and loads the register
//   defaults. Registers are written through cfg_we / cfg_addr / cfg_wdata;
//   the user must do so only while idle, the block does not enforce it.
// ----------------------------------------------------------------------------
module holonomic_waypoint_follower_core #(
  parameter int NUM_WAYPOINTS = hwf_pkg::NUM_WAYPOINTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [87:0]                    s_tdata,   // pos_x, pos_y, yaw, zero pad
  input  logic [0:0]                     s_tuser,   // func
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [71:0]                    m_tdata,   // wheel_0..3, waypoint_now,
                                                    // finished, zero pad
  input  logic                           cfg_we,
  input  logic [hwf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [hwf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(NUM_WAYPOINTS + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_WAYPOINTS);

  // configuration
  logic [15:0] tol_lin, tol_ang;
  logic [14:0] lin_speed, ang_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol_lin   <= hwf_pkg::TOL_LIN_RST;
      tol_ang   <= hwf_pkg::TOL_ANG_RST;
      lin_speed <= hwf_pkg::LIN_SPEED_RST;
      ang_speed <= hwf_pkg::ANG_SPEED_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        hwf_pkg::REG_TOL_LIN:   tol_lin   <= cfg_wdata;
        hwf_pkg::REG_TOL_ANG:   tol_ang   <= cfg_wdata;
        hwf_pkg::REG_LIN_SPEED: lin_speed <= cfg_wdata[14:0];
        hwf_pkg::REG_ANG_SPEED: ang_speed <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // stage enables, from the output back
  logic [8:1] vld;
  logic       v0, ovld;
  logic       en_out;
  logic [8:1] en;
  logic       tick0, adv0;
  logic       s_tuser_q;

  always_comb begin
    en_out = !ovld || m_tready;
    en[8]  = !vld[8] || en_out;
    for (int k = 7; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign tick0    = s_tuser_q;
  assign adv0     = v0 && (!tick0 || en[1]);
  assign s_tready = !v0 || adv0;

  // input register
  logic [31:0] in_x, in_y;
  logic [18:0] in_yaw;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      v0 <= 1'b1;
    end else if (adv0) begin
      v0 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s_tuser_q <= s_tuser[0];
      in_x      <= s_tdata[31:0];
      in_y      <= s_tdata[63:32];
      in_yaw    <= s_tdata[82:64];
    end
  end

  // waypoint state
  logic [31:0]      cur_x, cur_y, goal_x, goal_y;
  logic [18:0]      cur_heading;
  logic [19:0]      goal_heading;
  logic             need_setpoint, done_flag;
  logic [IDX_W-1:0] waypoint_idx;

  logic [31:0]      goal_x_next, goal_y_next;
  logic [19:0]      goal_heading_next;
  logic             need_setpoint_next, done_flag_next;
  logic [IDX_W-1:0] waypoint_idx_next;
  hwf_pkg::side_t   side0;
  logic [20:0]      dh0;

  logic             commit_tick;
  hwf_pkg::wp_t     wp;
  logic [31:0]      x_off, y_off;
  logic [32:0]      dx, dy, dx_mag, dy_mag;
  logic [20:0]      dh_mag0;
  logic             fx, fy, fh, all_zero;
  logic [IDX_W+3:0] idx_ext;

  assign commit_tick = adv0 && tick0 && !done_flag;

  always_comb begin
    wp = hwf_pkg::wp_t'(0);
    if (32'(waypoint_idx) < 32'(hwf_pkg::TABLE_LEN)) begin
      wp = hwf_pkg::wp_entry(8'(waypoint_idx));
    end
    x_off = wp.x_pos ? hwf_pkg::OFFSET_Q : (wp.x_neg ? -hwf_pkg::OFFSET_Q : 32'd0);
    y_off = wp.y_pos ? hwf_pkg::OFFSET_Q : (wp.y_neg ? -hwf_pkg::OFFSET_Q : 32'd0);

    if (need_setpoint) begin
      goal_x_next       = cur_x + x_off;
      goal_y_next       = cur_y + y_off;
      goal_heading_next = {cur_heading[18], cur_heading} + {wp.yaw[18], wp.yaw};
    end else begin
      goal_x_next       = goal_x;
      goal_y_next       = goal_y;
      goal_heading_next = goal_heading;
    end

    dx  = {goal_x_next[31], goal_x_next} - {cur_x[31], cur_x};
    dy  = {goal_y_next[31], goal_y_next} - {cur_y[31], cur_y};
    dh0 = {goal_heading_next[19], goal_heading_next} - {{2{cur_heading[18]}}, cur_heading};
    dx_mag  = dx[32] ? (~dx + 33'd1) : dx;
    dy_mag  = dy[32] ? (~dy + 33'd1) : dy;
    dh_mag0 = dh0[20] ? (~dh0 + 21'd1) : dh0;

    fx = dx_mag >= {17'd0, tol_lin};
    fy = dy_mag >= {17'd0, tol_lin};
    fh = dh_mag0 >= {5'd0, tol_ang};

    side0.x_pos = wp.x_pos && fx;
    side0.x_neg = wp.x_neg && fx;
    side0.y_pos = wp.y_pos && fy;
    side0.y_neg = wp.y_neg && fy;
    side0.h_pos = !wp.yaw[18] && (wp.yaw != 19'd0) && fh;
    side0.h_neg = wp.yaw[18] && fh;
    all_zero = !(side0.x_pos || side0.x_neg || side0.y_pos || side0.y_neg ||
                 side0.h_pos || side0.h_neg);

    need_setpoint_next = all_zero;
    waypoint_idx_next  = waypoint_idx;
    if (all_zero && (waypoint_idx < IDX_LAST)) begin
      waypoint_idx_next = waypoint_idx + IDX_W'(1);
    end
    done_flag_next = waypoint_idx_next >= IDX_LAST;

    // a finished block reports zero wheels
    if (done_flag || done_flag_next) begin
      side0.x_pos = 1'b0;
      side0.x_neg = 1'b0;
      side0.y_pos = 1'b0;
      side0.y_neg = 1'b0;
      side0.h_pos = 1'b0;
      side0.h_neg = 1'b0;
    end
    idx_ext         = {4'd0, (done_flag ? waypoint_idx : waypoint_idx_next)};
    side0.wp_now    = idx_ext[3:0];
    side0.finished  = done_flag || done_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x         <= '0;
      cur_y         <= '0;
      cur_heading   <= '0;
      goal_x        <= '0;
      goal_y        <= '0;
      goal_heading  <= '0;
      need_setpoint <= 1'b1;
      waypoint_idx  <= '0;
      done_flag     <= 1'b0;
    end else if (adv0 && !tick0) begin
      cur_x       <= in_x;
      cur_y       <= in_y;
      cur_heading <= in_yaw;
    end else if (commit_tick) begin
      goal_x        <= goal_x_next;
      goal_y        <= goal_y_next;
      goal_heading  <= goal_heading_next;
      need_setpoint <= need_setpoint_next;
      waypoint_idx  <= waypoint_idx_next;
      done_flag     <= done_flag_next;
    end
  end

  // cosine pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      ovld <= 1'b0;
    end else begin
      if (en[1]) vld[1] <= v0 && tick0;
      for (int k = 2; k <= 8; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
      if (en_out) ovld <= vld[8];
    end
  end

  hwf_pkg::side_t side1, side2, side3, side4, side5, side6, side7, side8;
  logic [20:0] s1_dh;
  logic [16:0] s2_r;
  logic [17:0] s3_x2, s4_x2, s5_x2, s6_x2;
  logic [13:0] s4_q1;
  logic [17:0] s5_y;
  logic [14:0] s6_q2;
  logic [17:0] s7_z;
  logic [15:0] s8_pm;
  logic s2_neg, s3_neg, s4_neg, s5_neg, s6_neg, s7_neg, s8_neg;

  // stage 1: reduce the heading error to [0, pi/2]
  logic [20:0] dh_mag1;
  logic [19:0] m1, r1, r1f;
  logic        neg1;
  always_comb begin
    dh_mag1 = s1_dh[20] ? (~s1_dh + 21'd1) : s1_dh;
    if (dh_mag1[19:0] >= hwf_pkg::FOUR_PI_Q) begin
      m1 = dh_mag1[19:0] - hwf_pkg::FOUR_PI_Q;
    end else if (dh_mag1[19:0] >= hwf_pkg::TWO_PI_Q) begin
      m1 = dh_mag1[19:0] - hwf_pkg::TWO_PI_Q;
    end else begin
      m1 = dh_mag1[19:0];
    end
    r1   = (m1 > hwf_pkg::PI_Q) ? (hwf_pkg::TWO_PI_Q - m1) : m1;
    neg1 = r1 > hwf_pkg::HALF_PI_Q;
    r1f  = neg1 ? (hwf_pkg::PI_Q - r1) : r1;
  end

  // stage 2..7: series terms
  logic [33:0] rr2;
  logic [36:0] p3, p5;
  logic [34:0] p4, p6;
  logic [16:0] t1, t2, c7;
  logic [18:0] t3;
  logic [31:0] p7;
  always_comb begin
    rr2 = s2_r * s2_r;
    p3  = s3_x2 * hwf_pkg::RECIP_30;
    t1  = hwf_pkg::ONE_Q - {3'd0, s4_q1};
    p4  = s4_x2 * t1;
    p5  = s5_y * hwf_pkg::RECIP_12;
    t2  = hwf_pkg::ONE_Q - {2'd0, s6_q2};
    p6  = s6_x2 * t2;
    t3  = {2'd0, hwf_pkg::ONE_Q} - {2'd0, s7_z[17:1]};
    if (t3[18]) begin
      c7 = 17'd0;
    end else if (t3 > {2'd0, hwf_pkg::ONE_Q}) begin
      c7 = hwf_pkg::ONE_Q;
    end else begin
      c7 = t3[16:0];
    end
    p7 = lin_speed * c7;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin side1 <= side0; s1_dh <= dh0; end
    if (en[2]) begin side2 <= side1; s2_r <= r1f[16:0]; s2_neg <= neg1; end
    if (en[3]) begin side3 <= side2; s3_x2 <= rr2[33:16]; s3_neg <= s2_neg; end
    if (en[4]) begin
      side4 <= side3; s4_x2 <= s3_x2; s4_q1 <= p3[36:23]; s4_neg <= s3_neg;
    end
    if (en[5]) begin
      side5 <= side4; s5_x2 <= s4_x2; s5_y <= p4[33:16]; s5_neg <= s4_neg;
    end
    if (en[6]) begin
      side6 <= side5; s6_x2 <= s5_x2; s6_q2 <= p5[36:22]; s6_neg <= s5_neg;
    end
    if (en[7]) begin side7 <= side6; s7_z <= p6[33:16]; s7_neg <= s6_neg; end
    if (en[8]) begin side8 <= side7; s8_pm <= p7[31:16]; s8_neg <= s7_neg; end
  end

  // stage 8: wheel mixing
  logic signed [17:0] p_s, a_s, tx, ty, th_t, w0, w1, w2, w3;
  always_comb begin
    p_s  = s8_neg ? -$signed({2'b00, s8_pm}) : $signed({2'b00, s8_pm});
    a_s  = $signed({3'b000, ang_speed});
    tx   = side8.x_pos ? p_s : (side8.x_neg ? -p_s : 18'sd0);
    ty   = side8.y_pos ? p_s : (side8.y_neg ? -p_s : 18'sd0);
    th_t = side8.h_pos ? a_s : (side8.h_neg ? -a_s : 18'sd0);
    w0   = tx - ty + th_t;
    w1   = tx + ty - th_t;
    w2   = tx + ty + th_t;
    w3   = tx - ty - th_t;
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      m_tdata <= {3'd0, side8.finished, side8.wp_now,
                  hwf_pkg::sat16(w3), hwf_pkg::sat16(w2),
                  hwf_pkg::sat16(w1), hwf_pkg::sat16(w0)};
    end
  end

  assign m_tvalid = ovld;

  // checks
  a_finished_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[68] |-> m_tdata[63:0] == 64'd0)
    else $error("finished result with nonzero wheels");

  a_done_sticks: assert property (@(posedge clk) disable iff (rst)
    done_flag |=> done_flag)
    else $error("finished flag cleared without reset");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    waypoint_idx <= IDX_LAST)
    else $error("waypoint index past end of list");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> v0 && tick0 && (&vld) && ovld && !m_tready)
    else $error("input stalled with room in the pipeline");

endmodule

// ----- test/holonomic_waypoint_follower_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// holonomic_waypoint_follower_core_tb - self-checking bench for the follower
// Drives pose updates and control ticks on the request stream and keeps its
// own copy of the waypoint state to work out each wheel command. It walks the
// route once: directed tolerance, wrap and zero-gain requests first, then
// random poses that mostly wander around the goal and now and then reach it.
// ----------------------------------------------------------------------------
module holonomic_waypoint_follower_core_tb;

  localparam int WAYPOINT_COUNT = hwf_pkg::NUM_WAYPOINTS_DEF;
  localparam int WP_TABLE_SIZE  = hwf_pkg::TABLE_LEN;
  localparam logic FUNC_POSE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam longint Q_ONE     = 65536;
  localparam longint Q_TWO_PI  = 411775;
  localparam longint Q_PI      = 205887;
  localparam longint Q_HALF_PI = 102944;
  localparam longint YAW_MAX   = 205888;

  localparam int ROUTE_PACE  = 100;  // requests between allowed waypoint passes
  localparam int SETTLE_CYC  = 16;

  typedef struct packed {
    logic [3:0][15:0] wheel;
    logic [3:0]       wp_now;
    logic             finished;
  } cmd_t;

  logic                           clk;
  logic                           rst       = 1'b1;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [87:0]                    s_tdata   = '0;  // pos_x, pos_y, yaw, zero pad
  logic [0:0]                     s_tuser   = '0;  // func
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  logic [71:0]                    m_tdata;         // wheel_0..3, waypoint_now, finished, pad
  logic                           cfg_we    = 1'b0;
  logic [hwf_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [hwf_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // waypoint offsets: heading in Q16.16, x and y as unit signs
  int wp_yaw [WP_TABLE_SIZE] = '{0, 0, 0, 102944, -205883, 0, 0, 0, 0};
  int wp_dx  [WP_TABLE_SIZE] = '{1, 1, 1, 1, -1, -1, -1, -1, 0};
  int wp_dy  [WP_TABLE_SIZE] = '{-1, 1, 1, -1, -1, 1, 1, -1, 0};

  // follower state as the bench sees it
  longint tol_lin, tol_ang, lin_spd, ang_spd;
  longint cur_x, cur_y, cur_hd, goal_x, goal_y, goal_hd;
  bit     need_setpoint, done_flag;
  int     wp_idx;

  cmd_t   cmd_q [$];
  cmd_t   front_cmd;
  int     err_count   = 0;
  int     req_count   = 0;
  int     tx_idle_pct = 0;
  int     rx_idle_pct = 0;

  holonomic_waypoint_follower_core #(
    .NUM_WAYPOINTS(WAYPOINT_COUNT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("holonomic_waypoint_follower_core test failed");
    $finish;
  end

  // cosine of a heading error, Q16.16, by range reduction and a series
  function automatic longint cos_fixed(input longint e);
    longint r, x2, t;
    bit     neg;
    neg = 1'b0;
    r = (e < 0) ? -e : e;
    r = r % Q_TWO_PI;
    if (r > Q_PI) r = Q_TWO_PI - r;
    if (r > Q_HALF_PI) begin
      r = Q_PI - r;
      neg = 1'b1;
    end
    x2 = (r * r) >> 16;
    t = Q_ONE - x2 / 30;
    t = Q_ONE - ((x2 * t) / Q_ONE) / 12;
    t = Q_ONE - ((x2 * t) / Q_ONE) / 2;
    if (t < 0) t = 0;
    if (t > Q_ONE) t = Q_ONE;
    return neg ? -t : t;
  endfunction

  // applies one accepted request to the bench state; a tick queues a command
  task automatic step_follower(input logic func, input logic [31:0] px,
                               input logic [31:0] py, input logic [18:0] ph);
    longint      wh [4];
    longint      th, p, a, dx, dy, dh, v;
    int          sx, sy, i;
    logic [31:0] g32;
    cmd_t        c;
    if (func == FUNC_POSE) begin
      cur_x  = longint'($signed(px));
      cur_y  = longint'($signed(py));
      cur_hd = longint'($signed(ph));
    end else begin
      for (i = 0; i < 4; i++) wh[i] = 0;
      if (!done_flag) begin
        th = 0;
        sx = 0;
        sy = 0;
        if (wp_idx < WP_TABLE_SIZE) begin
          th = wp_yaw[wp_idx];
          sx = wp_dx[wp_idx];
          sy = wp_dy[wp_idx];
        end
        if (need_setpoint) begin
          g32 = 32'(cur_x + sx * Q_ONE);
          goal_x = longint'($signed(g32));
          g32 = 32'(cur_y + sy * Q_ONE);
          goal_y = longint'($signed(g32));
          goal_hd = cur_hd + th;
          need_setpoint = 1'b0;
        end
        dx = goal_x - cur_x;
        dy = goal_y - cur_y;
        dh = goal_hd - cur_hd;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (dx < tol_lin) sx = 0;
        if (dy < tol_lin) sy = 0;
        p = (lin_spd * cos_fixed(dh)) / Q_ONE;
        if (dh < 0) dh = -dh;
        if (dh < tol_ang) th = 0;
        a = ang_spd;
        // mixing follows the waypoint signs, not the error signs
        if (sx > 0) for (i = 0; i < 4; i++) wh[i] += p;
        if (sx < 0) for (i = 0; i < 4; i++) wh[i] -= p;
        if (sy > 0) begin wh[0] -= p; wh[1] += p; wh[2] += p; wh[3] -= p; end
        if (sy < 0) begin wh[0] += p; wh[1] -= p; wh[2] -= p; wh[3] += p; end
        if (th > 0) begin wh[0] += a; wh[1] -= a; wh[2] += a; wh[3] -= a; end
        if (th < 0) begin wh[0] -= a; wh[1] += a; wh[2] -= a; wh[3] += a; end
        if (sx == 0 && sy == 0 && th == 0) begin
          need_setpoint = 1'b1;
          if (wp_idx < WAYPOINT_COUNT) wp_idx++;
        end
        if (wp_idx >= WAYPOINT_COUNT) begin
          done_flag = 1'b1;
          for (i = 0; i < 4; i++) wh[i] = 0;
        end
      end
      for (i = 0; i < 4; i++) begin
        v = wh[i];
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        c.wheel[i] = v[15:0];
      end
      c.wp_now   = wp_idx[3:0];
      c.finished = done_flag;
      cmd_q.push_back(c);
    end
  endtask

  task automatic report(input string what, input logic [63:0] got,
                        input logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    err_count++;
  endtask

  task automatic send_req(input logic func, input logic [31:0] px,
                          input logic [31:0] py, input logic [18:0] ph);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {5'd0, ph, py, px};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    step_follower(func, px, py, ph);
    req_count++;
  endtask

  function automatic logic [18:0] rand_yaw();
    longint v;
    v = longint'($urandom_range(32'(2 * YAW_MAX))) - YAW_MAX;
    return v[18:0];
  endfunction

  // tick payload is ignored by the block, so fill it with noise
  task automatic send_tick();
    send_req(FUNC_TICK, $urandom, $urandom, rand_yaw());
  endtask

  // center moved by less than tol on a hit, by tol or more on a miss
  function automatic longint shifted(input longint center, input longint tol,
                                     input bit hit);
    longint off;
    if (hit) off = (tol > 0) ? longint'($urandom_range(32'(tol - 1))) : 0;
    else off = tol + $urandom_range(131072);
    if ($urandom_range(1)) off = -off;
    return center + off;
  endfunction

  // waits out every pending result, then lets the pose pipeline drain
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (cmd_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] tl, input logic [15:0] ta,
                            input logic [15:0] ls, input logic [15:0] as);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_addr  <= hwf_pkg::REG_TOL_LIN;
    cfg_wdata <= tl;
    @(posedge clk);
    tol_lin = longint'(tl);
    cfg_addr  <= hwf_pkg::REG_TOL_ANG;
    cfg_wdata <= ta;
    @(posedge clk);
    tol_ang = longint'(ta);
    cfg_addr  <= hwf_pkg::REG_LIN_SPEED;
    cfg_wdata <= ls;
    @(posedge clk);
    lin_spd = longint'(ls[14:0]);
    cfg_addr  <= hwf_pkg::REG_ANG_SPEED;
    cfg_wdata <= as;
    @(posedge clk);
    ang_spd = longint'(as[14:0]);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (cmd_q.size() == 0) begin
        report("result with no tick pending", 64'(m_tdata[68:0]), 64'd0);
      end else begin
        front_cmd = cmd_q.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (m_tdata[16*i +: 16] !== front_cmd.wheel[i])
            report($sformatf("wheel_%0d", i), 64'(m_tdata[16*i +: 16]),
                   64'(front_cmd.wheel[i]));
        end
        if (m_tdata[67:64] !== front_cmd.wp_now)
          report("waypoint_now", 64'(m_tdata[67:64]), 64'(front_cmd.wp_now));
        if (m_tdata[68] !== front_cmd.finished)
          report("finished", 64'(m_tdata[68]), 64'(front_cmd.finished));
      end
    end
  end

  // reset defaults, first setpoint from the zero pose, extreme headings
  task automatic test_first_setpoint();
    send_tick();
    send_req(FUNC_POSE, 32'h7fff_ffff, 32'h8000_0000, YAW_MAX[18:0]);
    send_tick();
    send_req(FUNC_POSE, 32'h0, 32'h0, 19'(-YAW_MAX));
    send_tick();
  endtask

  // error equal to the tolerance keeps the axis, one below clears it
  task automatic test_tolerance_edge();
    logic [31:0] x, y;
    x = 32'(goal_x - tol_lin);
    send_req(FUNC_POSE, x, goal_y[31:0], 19'd0);
    send_tick();
    x = 32'(goal_x + tol_lin - 1);
    y = 32'(goal_y - tol_lin + 1);
    send_req(FUNC_POSE, x, y, 19'(tol_ang - 1));
    send_tick();
  endtask

  // goal past the 32-bit edge wraps; the raw difference then stays huge
  task automatic test_goal_wrap();
    send_req(FUNC_POSE, 32'h7fff_ffff, 32'h7fff_ffff, 19'd0);
    send_tick();
    send_req(FUNC_POSE, goal_x[31:0], goal_y[31:0], 19'd0);
    send_tick();
  endtask

  // zero tolerances never clear an axis, zero speeds give zero wheels
  task automatic test_zero_gains();
    write_regs(16'd0, 16'd0, 16'd0, 16'd0);
    send_req(FUNC_POSE, 32'h0, 32'h0, 19'd0);
    send_tick();
    send_req(FUNC_POSE, goal_x[31:0], goal_y[31:0], goal_hd[18:0]);
    send_tick();
  endtask

  // one or two random requests shaped by where the route stands
  task automatic route_step();
    int          kind;
    bit          reach, miss_y;
    longint      th, lo, hi, v;
    logic [31:0] x, y;
    kind = $urandom_range(9);
    if (done_flag) begin
      if (kind < 5) send_tick();
      else send_req(FUNC_POSE, $urandom, $urandom, rand_yaw());
    end else if (need_setpoint) begin
      // start heading chosen so the new goal heading stays reachable
      th = (wp_idx < WP_TABLE_SIZE) ? wp_yaw[wp_idx] : 0;
      lo = -YAW_MAX + ((th < 0) ? -th : 0);
      hi = YAW_MAX - ((th > 0) ? th : 0);
      v = lo + $urandom_range(32'(hi - lo));
      if (kind < 2) begin
        x = 32'h7fff_ffff - $urandom_range(32'(2 * Q_ONE));
        y = 32'h8000_0000 + $urandom_range(32'(2 * Q_ONE));
      end else begin
        x = $urandom;
        y = $urandom;
      end
      send_req(FUNC_POSE, x, y, v[18:0]);
      send_tick();
    end else if (kind == 0) begin
      send_tick();
    end else if (kind == 1) begin
      send_req(FUNC_POSE, $urandom, $urandom, rand_yaw());
      if ($urandom_range(1)) send_tick();
    end else begin
      // short of the pace, one linear axis is kept outside its tolerance
      reach  = (kind >= 7) && (req_count >= wp_idx * ROUTE_PACE);
      miss_y = 1'($urandom_range(1));
      x = 32'(shifted(goal_x, tol_lin, reach || miss_y));
      y = 32'(shifted(goal_y, tol_lin, reach || !miss_y));
      v = shifted(goal_hd, tol_ang, reach || ($urandom_range(9) < 7));
      if (v > YAW_MAX) v = YAW_MAX;
      if (v < -YAW_MAX) v = -YAW_MAX;
      send_req(FUNC_POSE, x, y, v[18:0]);
      send_tick();
    end
  endtask

  task automatic test_route(input int end_count, input int tx_pct, input int rx_pct,
                            input logic [15:0] tl, input logic [15:0] ta,
                            input logic [15:0] ls, input logic [15:0] as);
    write_regs(tl, ta, ls, as);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    while (req_count < end_count) route_step();
  endtask

  initial begin
    tol_lin = longint'(hwf_pkg::TOL_LIN_RST);
    tol_ang = longint'(hwf_pkg::TOL_ANG_RST);
    lin_spd = longint'(hwf_pkg::LIN_SPEED_RST);
    ang_spd = longint'(hwf_pkg::ANG_SPEED_RST);
    cur_x = 0;
    cur_y = 0;
    cur_hd = 0;
    goal_x = 0;
    goal_y = 0;
    goal_hd = 0;
    need_setpoint = 1'b1;
    done_flag = 1'b0;
    wp_idx = 0;
    tx_idle_pct = 27;
    rx_idle_pct = 55;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_first_setpoint();
    test_tolerance_edge();
    test_goal_wrap();
    test_zero_gains();
    test_route(330, 27, 55, 16'hffff, 16'hffff, 16'h7fff, 16'h7fff);
    test_route(640, 55, 27, 16'(2048 + $urandom_range(63487)),
               16'(2048 + $urandom_range(63487)),
               16'($urandom_range(32767)), 16'($urandom_range(32767)));
    test_route(950, 0, 0, 16'(2048 + $urandom_range(63487)),
               16'(2048 + $urandom_range(63487)),
               16'($urandom_range(65535)), 16'($urandom_range(65535)));

    wait_idle();
    if (err_count == 0) begin
      $display("holonomic_waypoint_follower_core test passed");
    end else begin
      $display("holonomic_waypoint_follower_core test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/hwf_pkg.sv
rtl/holonomic_waypoint_follower_core.sv
test/holonomic_waypoint_follower_core_tb.sv
